// File: design/srlp_pkg.sv
// ----------------------------------------------------------------------------
// srlp_pkg: shared types and constants of the SMTP reply line parser
// Holds the character codes, the line offsets, the phase and status codes and
// the structs that carry parser state and one result between modules.
// ----------------------------------------------------------------------------
package srlp_pkg;

   // Field widths.
   localparam int ByteWidth   = 8;
   localparam int CodeWidth   = 10;
   localparam int StatusWidth = 3;
   localparam int CountWidth  = 16;
   localparam int OffsetWidth = 3;

   // Characters that the line syntax depends on.
   localparam logic [ByteWidth-1:0] CharSpace = 8'h20;
   localparam logic [ByteWidth-1:0] CharCr    = 8'h0D;
   localparam logic [ByteWidth-1:0] CharLf    = 8'h0A;
   localparam logic [ByteWidth-1:0] CharZero  = 8'h30;
   localparam logic [ByteWidth-1:0] CharNine  = 8'h39;

   // Offsets within a line. The offset saturates at OffsetSat.
   localparam logic [OffsetWidth-1:0] CodeDigits = 3'd3;
   localparam logic [OffsetWidth-1:0] TextStart  = 3'd4;
   localparam logic [OffsetWidth-1:0] OffsetSat  = 3'd5;

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   // Parser phase.
   typedef enum logic [1:0] {
      PH_PARSE = 2'd0,
      PH_DONE  = 2'd1,
      PH_ERROR = 2'd2
   } srlp_phase_type;

   // Status codes reported with each result.
   typedef enum logic [StatusWidth-1:0] {
      ST_BUSY     = 3'd0,
      ST_COMPLETE = 3'd1,
      ST_ERROR    = 3'd2,
      ST_NO_FINAL = 3'd3,
      ST_IGNORED  = 3'd4
   } srlp_status_type;

   // Parser state carried from one request to the next.
   typedef struct packed {
      logic [OffsetWidth-1:0] line_offset;
      logic [CodeWidth-1:0]   code_accum;
      logic                   final_line_flag;
      logic [ByteWidth-1:0]   held_byte;
      srlp_phase_type         phase;
      logic [CountWidth-1:0]  byte_count;
   } srlp_state_type;

   localparam srlp_state_type StateReset = '{
      line_offset:     '0,
      code_accum:      '0,
      final_line_flag: 1'b0,
      held_byte:       '0,
      phase:           PH_PARSE,
      byte_count:      '0
   };

   // One result.
   typedef struct packed {
      logic [ByteWidth-1:0]  out_byte;
      logic                  out_valid;
      logic                  line_done;
      logic                  line_is_last;
      logic [CodeWidth-1:0]  reply_code;
      srlp_status_type       status;
      logic [CountWidth-1:0] consumed;
   } srlp_result_type;

endpackage

// File: design/srlp_if.sv
// ----------------------------------------------------------------------------
// srlp_if: request and response channels of the SMTP reply line parser
// Valid/ready channels; a request or response moves at a rising clock edge at
// which valid and ready are both high.
// ----------------------------------------------------------------------------
interface srlp_req_if import srlp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] text_byte;
   logic                 buffer_end;

   modport source (output valid, output text_byte, output buffer_end, input ready);
   modport sink   (input valid, input text_byte, input buffer_end, output ready);
endinterface

interface srlp_rsp_if import srlp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ByteWidth-1:0]   out_byte;
   logic                   out_valid;
   logic                   line_done;
   logic                   line_is_last;
   logic [CodeWidth-1:0]   reply_code;
   logic [StatusWidth-1:0] status;
   logic [CountWidth-1:0]  consumed;

   modport source (output valid, output out_byte, output out_valid, output line_done,
                   output line_is_last, output reply_code, output status,
                   output consumed, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input line_done,
                   input line_is_last, input reply_code, input status,
                   input consumed, output ready);
endinterface

// File: design/srlp_step.sv
// ----------------------------------------------------------------------------
// srlp_step: per-byte parser logic
// From the current state and one request byte, computes the next state and
// the result for that byte. Purely combinational.
// ----------------------------------------------------------------------------
module srlp_step import srlp_pkg::*; (
   input  srlp_state_type       cur_state,
   input  logic [ByteWidth-1:0] text_byte,
   input  logic                 buffer_end,
   output srlp_state_type       nxt_state,
   output srlp_result_type      result
);

   logic                 is_digit;
   logic                 crlf_seen;
   logic [CodeWidth+3:0] code_times_ten;

   assign is_digit  = text_byte inside {[CharZero:CharNine]};
   assign crlf_seen = (cur_state.held_byte == CharCr) && (text_byte == CharLf);

   // Code times ten plus the new digit, done as two shifts and adds.
   assign code_times_ten = {1'b0, cur_state.code_accum, 3'b000}
                         + {3'b000, cur_state.code_accum, 1'b0}
                         + {{(CodeWidth+4-4){1'b0}}, text_byte[3:0]};

   // Next state and result.
   always_comb begin
      logic err;
      err       = 1'b0;
      nxt_state = cur_state;
      result    = '0;
      result.status = ST_BUSY;

      if (cur_state.phase != PH_PARSE) begin
         result.status = ST_IGNORED;
      end else begin
         if (cur_state.byte_count != CountMax) begin
            nxt_state.byte_count = cur_state.byte_count + 1'b1;
         end

         if (cur_state.line_offset < CodeDigits) begin
            // Reply code digits.
            if (is_digit) begin
               nxt_state.code_accum  = code_times_ten[CodeWidth-1:0];
               nxt_state.line_offset = cur_state.line_offset + 1'b1;
               err = buffer_end;
            end else begin
               err = 1'b1;
            end
         end else if (cur_state.line_offset == CodeDigits) begin
            // Separator: a space marks the final line.
            nxt_state.final_line_flag = (text_byte == CharSpace);
            nxt_state.held_byte       = text_byte;
            nxt_state.line_offset     = TextStart;
            err = buffer_end;
         end else if (cur_state.line_offset == TextStart) begin
            // A buffer ending in digits, CR, LF is a final line with no text.
            if (buffer_end) begin
               if (crlf_seen) begin
                  result.line_done    = 1'b1;
                  result.line_is_last = 1'b1;
                  result.reply_code   = cur_state.code_accum;
                  result.status       = ST_COMPLETE;
                  nxt_state.phase     = PH_DONE;
               end else begin
                  err = 1'b1;
               end
            end else begin
               nxt_state.held_byte   = text_byte;
               nxt_state.line_offset = OffsetSat;
            end
         end else begin
            // Text: the held byte goes out unless it opens the line end.
            if (crlf_seen) begin
               result.line_done = 1'b1;
               if (cur_state.final_line_flag) begin
                  result.line_is_last = 1'b1;
                  result.reply_code   = cur_state.code_accum;
                  result.status       = ST_COMPLETE;
                  nxt_state.phase     = PH_DONE;
               end else begin
                  nxt_state.line_offset     = '0;
                  nxt_state.code_accum      = '0;
                  nxt_state.final_line_flag = 1'b0;
                  nxt_state.held_byte       = '0;
                  if (buffer_end) begin
                     result.status = ST_NO_FINAL;
                  end
               end
            end else begin
               result.out_byte     = cur_state.held_byte;
               result.out_valid    = 1'b1;
               nxt_state.held_byte = text_byte;
               err = buffer_end;
            end
         end

         if (err) begin
            result.status   = ST_ERROR;
            nxt_state.phase = PH_ERROR;
         end
      end

      result.consumed = nxt_state.byte_count;

      // The last byte of a buffer returns the parser to its reset state.
      if (buffer_end) begin
         nxt_state = StateReset;
      end
   end

endmodule

// File: design/smtp_reply_line_parser.sv
// ----------------------------------------------------------------------------
// smtp_reply_line_parser: SMTP reply line parser, top level
// Parses a reply buffer one byte per request and returns one response per
// request, with text bytes, line completion, the final reply code and status.
// ----------------------------------------------------------------------------
// The parser takes one byte of the reply buffer in every unstalled cycle and
// returns its response in the cycle after the request is taken. All per-byte
// work is done between the parser state registers and the response register,
// so a new request is taken whenever the response register is empty or its
// response is being taken in the same cycle; a stalled response channel
// stalls requests only once that register holds an untaken response. Text
// bytes appear one request late, since a CR is held until the next byte
// shows whether it ends the line. After the request that carries
// buffer_end, the parser is back in its reset state for the next buffer.
module smtp_reply_line_parser import srlp_pkg::*; (
   input logic            clock,
   input logic            reset,
   srlp_req_if.sink       req_bus,
   srlp_rsp_if.source     rsp_bus
);

   srlp_state_type  state_ff;
   srlp_state_type  state_in;
   srlp_result_type result_ff;
   srlp_result_type result_in;
   logic            rsp_valid_ff;
   logic            req_accept;

   // Request handshake: the response register parts the two sides.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   srlp_step u_step (
      .cur_state  (state_ff),
      .text_byte  (req_bus.text_byte),
      .buffer_end (req_bus.buffer_end),
      .nxt_state  (state_in),
      .result     (result_in)
   );

   // Parser state and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StateReset;
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_byte     = result_ff.out_byte;
   assign rsp_bus.out_valid    = result_ff.out_valid;
   assign rsp_bus.line_done    = result_ff.line_done;
   assign rsp_bus.line_is_last = result_ff.line_is_last;
   assign rsp_bus.reply_code   = result_ff.reply_code;
   assign rsp_bus.status       = result_ff.status;
   assign rsp_bus.consumed     = result_ff.consumed;

`ifndef SYNTH
   // The line offset never passes its saturation point.
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.line_offset <= OffsetSat)
      else $error("line offset beyond saturation");

   // The end of a buffer returns the consumed count to zero and the phase to parse.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_bus.buffer_end |=> state_ff.byte_count == '0
                                          && state_ff.phase == PH_PARSE)
      else $error("state not cleared after end of buffer");

   // A request taken after completion or an error is reported as ignored.
   a_ignored: assert property (@(posedge clock) disable iff (reset)
      req_accept && state_ff.phase != PH_PARSE |=> result_ff.status == ST_IGNORED)
      else $error("request after completion not ignored");

   // A final line always reports completion.
   a_last_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.line_is_last |->
         result_ff.line_done && result_ff.status == ST_COMPLETE)
      else $error("final line without completion");

   // Text bytes only come out while busy or on the error byte.
   a_text_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.out_valid |->
         result_ff.status == ST_BUSY || result_ff.status == ST_ERROR)
      else $error("text byte with unexpected status");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the SMTP reply line parser
// Sends reply buffers byte by byte through the request channel and checks
// every response against a cycle-free model of the parser that tracks line
// offset, reply code, held text byte, phase and byte count. Covers hand-made
// corner buffers, random well-formed and broken replies, and a buffer with
// one long text line. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top import srlp_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomBytes = 820;
   localparam int LongText    = 200;

   logic clock;
   logic reset;

   srlp_req_if req_bus ();
   srlp_rsp_if rsp_bus ();

   smtp_reply_line_parser u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Model state of the parser.
   logic [OffsetWidth-1:0] model_offset;
   logic [CodeWidth-1:0]   model_code;
   logic                   model_is_final;
   logic [ByteWidth-1:0]   model_held;
   srlp_phase_type         model_phase;
   logic [CountWidth-1:0]  model_count;

   // Responses still to come, oldest first.
   srlp_result_type pending_results[$];

   int  error_count   = 0;
   int  parsed_count  = 0;
   int  response_seen = 0;
   bit  sender_quiet  = 1'b0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run in case the handshake hangs.
   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Prints one line for each of the first 50 failures and keeps the count of all.
   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 50) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endtask

   // Gap length: mostly none or short, now and then long.
   function automatic int draw_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 85) begin
         return $urandom_range(1, 3);
      end else if (pick < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   // Returns the model to the state it holds after reset or a buffer end.
   function automatic void clear_model();
      model_offset   = '0;
      model_code     = '0;
      model_is_final = 1'b0;
      model_held     = '0;
      model_phase    = PH_PARSE;
      model_count    = '0;
   endfunction

   // Works out the response to one byte and advances the model state.
   function automatic srlp_result_type parse_reply_byte(input logic [ByteWidth-1:0] value,
                                                        input logic ends);
      srlp_result_type res;
      logic fail;
      res        = '0;
      res.status = ST_BUSY;
      fail       = 1'b0;
      if (model_phase != PH_PARSE) begin
         res.status = ST_IGNORED;
      end else begin
         if (model_count != CountMax) begin
            model_count = model_count + 1'b1;
         end
         if (model_offset < CodeDigits) begin
            // Code digits.
            if (value >= CharZero && value <= CharNine) begin
               model_code   = CodeWidth'(model_code * 10 + (value - CharZero));
               model_offset = model_offset + 1'b1;
               fail         = ends;
            end else begin
               fail = 1'b1;
            end
         end else if (model_offset == CodeDigits) begin
            // Separator: a space marks the final line.
            model_is_final = (value == CharSpace);
            model_held     = value;
            model_offset   = TextStart;
            fail           = ends;
         end else if (model_offset == TextStart) begin
            // A buffer may end with a bare code line, digits then CR LF.
            if (ends) begin
               if (model_held == CharCr && value == CharLf) begin
                  res.line_done    = 1'b1;
                  res.line_is_last = 1'b1;
                  res.reply_code   = model_code;
                  res.status       = ST_COMPLETE;
                  model_phase      = PH_DONE;
               end else begin
                  fail = 1'b1;
               end
            end else begin
               model_held   = value;
               model_offset = OffsetSat;
            end
         end else if (model_held == CharCr && value == CharLf) begin
            // Line end.
            res.line_done = 1'b1;
            if (model_is_final) begin
               res.line_is_last = 1'b1;
               res.reply_code   = model_code;
               res.status       = ST_COMPLETE;
               model_phase      = PH_DONE;
            end else begin
               model_offset   = '0;
               model_code     = '0;
               model_is_final = 1'b0;
               model_held     = '0;
               if (ends) begin
                  res.status = ST_NO_FINAL;
               end
            end
         end else begin
            // Text byte leaves one request late.
            res.out_byte  = model_held;
            res.out_valid = 1'b1;
            model_held    = value;
            fail          = ends;
         end
         if (fail) begin
            res.status  = ST_ERROR;
            model_phase = PH_ERROR;
         end
      end
      res.consumed = model_count;
      if (ends) begin
         clear_model();
      end
      return res;
   endfunction

   // Sends one request after a random gap, none while the sender is quiet, and records its expected response.
   task automatic send_byte(input logic [ByteWidth-1:0] value, input logic ends);
      int gap;
      srlp_result_type want;
      gap = sender_quiet ? 0 : draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.text_byte  <= value;
      req_bus.buffer_end <= ends;
      do @(posedge clock); while (!req_bus.ready);
      want = parse_reply_byte(value, ends);
      pending_results.insert(pending_results.size(), want);
      if (want.status != ST_IGNORED) begin
         parsed_count++;
      end
   endtask

   // Sends the characters of a string, the last one optionally ending the buffer.
   task automatic send_text(input string s, input logic ends);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], ends && (i == s.len() - 1));
      end
   endtask

   task automatic send_buffer(input logic [ByteWidth-1:0] buf_q[$]);
      for (int i = 0; i < buf_q.size(); i++) begin
         send_byte(buf_q[i], i == buf_q.size() - 1);
      end
   endtask

   // Text byte mix: mostly printable, some raw bytes and stray CR or LF.
   function automatic logic [ByteWidth-1:0] random_text_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         return ByteWidth'($urandom_range(8'h20, 8'h7E));
      end else if (pick < 85) begin
         return ByteWidth'($urandom_range(0, 255));
      end else if (pick < 95) begin
         return CharCr;
      end
      return CharLf;
   endfunction

   // Appends one reply line; the bare form is three digits then CR LF.
   task automatic append_line(ref logic [ByteWidth-1:0] buf_q[$], input bit is_final,
                              input bit bare);
      int text_len;
      logic [ByteWidth-1:0] sep;
      for (int i = 0; i < 3; i++) begin
         buf_q.insert(buf_q.size(), ByteWidth'(CharZero + $urandom_range(0, 9)));
      end
      if (!bare) begin
         if (is_final) begin
            sep = CharSpace;
         end else if ($urandom_range(0, 3) == 0) begin
            do sep = ByteWidth'($urandom_range(0, 255)); while (sep == CharSpace);
         end else begin
            sep = "-";
         end
         buf_q.insert(buf_q.size(), sep);
         text_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 12);
         for (int i = 0; i < text_len; i++) begin
            buf_q.insert(buf_q.size(), random_text_byte());
         end
      end
      buf_q.insert(buf_q.size(), CharCr);
      buf_q.insert(buf_q.size(), CharLf);
   endtask

   // One random buffer: well-formed, cut short, bad digit, no final line or noise.
   task automatic send_random_buffer();
      logic [ByteWidth-1:0] buf_q[$];
      int line_starts[$];
      int kind, nlines, idx, cut, extra;
      bit bare, has_final;
      logic [ByteWidth-1:0] bad;
      kind      = $urandom_range(0, 99);
      nlines    = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
      has_final = (kind < 85);
      bare      = has_final && ($urandom_range(0, 6) == 0);
      if (kind >= 93) begin
         extra = $urandom_range(1, 8);
         for (int i = 0; i < extra; i++) begin
            buf_q.insert(buf_q.size(), ByteWidth'($urandom_range(0, 255)));
         end
      end else begin
         for (int n = 0; n < nlines; n++) begin
            line_starts.insert(line_starts.size(), buf_q.size());
            append_line(buf_q, has_final && (n == nlines - 1),
                        bare && (n == nlines - 1));
         end
         if (kind < 60) begin
            // Trailing bytes after the final line are ignored.
            if (!bare && $urandom_range(0, 3) == 0) begin
               extra = $urandom_range(1, 4);
               for (int i = 0; i < extra; i++) begin
                  buf_q.insert(buf_q.size(), ByteWidth'($urandom_range(0, 255)));
               end
            end
         end else if (kind < 75) begin
            cut = $urandom_range(1, buf_q.size() - 1);
            while (buf_q.size() > cut) begin
               void'(buf_q.pop_back());
            end
         end else if (kind < 85) begin
            idx = line_starts[$urandom_range(0, line_starts.size() - 1)]
                  + $urandom_range(0, 2);
            do bad = ByteWidth'($urandom_range(0, 255));
            while (bad >= CharZero && bad <= CharNine);
            buf_q[idx] = bad;
         end
      end
      send_buffer(buf_q);
   endtask

   // Hand-made corner buffers.
   task automatic test_directed_cases();
      sender_quiet = 1'b0;
      // Buffer ends inside the code.
      send_text("2", 1'b1);
      // Non-digit in the code, then an ignored byte that ends the buffer.
      send_text("5A", 1'b0);
      send_byte(8'hFF, 1'b1);
      // Bare final line with no text.
      send_text("220", 1'b0);
      send_byte(CharCr, 1'b0);
      send_byte(CharLf, 1'b1);
      // Buffer ends right after a line that is not final.
      send_text("999-", 1'b0);
      send_byte(CharCr, 1'b0);
      send_byte(CharLf, 1'b1);
      // Final line with extreme text bytes, then a byte after completion.
      send_text("000 ", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CharCr, 1'b0);
      send_byte(CharLf, 1'b0);
      send_text("Z", 1'b1);
   endtask

   // Random buffers, with stretches where the sender never idles.
   task automatic test_random_replies();
      int start_count;
      start_count = parsed_count;
      while (parsed_count - start_count < RandomBytes) begin
         if ($urandom_range(0, 9) == 0) begin
            sender_quiet = !sender_quiet;
         end
         send_random_buffer();
      end
      sender_quiet = 1'b0;
   endtask

   // One long continuation line sent back to back, then a short final line.
   task automatic test_long_line();
      sender_quiet = 1'b1;
      send_text("250-", 1'b0);
      for (int i = 0; i < LongText; i++) begin
         send_byte(ByteWidth'($urandom_range(8'h21, 8'h7E)), 1'b0);
      end
      send_byte(CharCr, 1'b0);
      send_byte(CharLf, 1'b0);
      send_text("221 Bye", 1'b0);
      send_byte(CharCr, 1'b0);
      send_byte(CharLf, 1'b1);
      sender_quiet = 1'b0;
   endtask

   // Response ready with random stalls and stretches without any.
   initial begin : rsp_ready_driver
      int stall_left;
      int quiet_left;
      stall_left    = 0;
      quiet_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (quiet_left > 0) begin
               quiet_left--;
            end else if ($urandom_range(0, 199) == 0) begin
               quiet_left = $urandom_range(50, 300);
            end else if ($urandom_range(0, 2) == 0) begin
               stall_left = draw_gap();
            end
         end
      end
   end

   // Compares each taken response with the oldest expected one.
   always @(posedge clock) begin
      srlp_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_error($sformatf("response %0d arrived with none expected", response_seen));
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.out_byte !== want.out_byte)
               report_error($sformatf("response %0d out_byte 0x%0h, expected 0x%0h",
                                      response_seen, rsp_bus.out_byte, want.out_byte));
            if (rsp_bus.out_valid !== want.out_valid)
               report_error($sformatf("response %0d out_valid %0b, expected %0b",
                                      response_seen, rsp_bus.out_valid, want.out_valid));
            if (rsp_bus.line_done !== want.line_done)
               report_error($sformatf("response %0d line_done %0b, expected %0b",
                                      response_seen, rsp_bus.line_done, want.line_done));
            if (rsp_bus.line_is_last !== want.line_is_last)
               report_error($sformatf("response %0d line_is_last %0b, expected %0b",
                                      response_seen, rsp_bus.line_is_last,
                                      want.line_is_last));
            if (rsp_bus.reply_code !== want.reply_code)
               report_error($sformatf("response %0d reply_code %0d, expected %0d",
                                      response_seen, rsp_bus.reply_code, want.reply_code));
            if (rsp_bus.status !== want.status)
               report_error($sformatf("response %0d status %0d, expected %0d",
                                      response_seen, rsp_bus.status, want.status));
            if (rsp_bus.consumed !== want.consumed)
               report_error($sformatf("response %0d consumed %0d, expected %0d",
                                      response_seen, rsp_bus.consumed, want.consumed));
         end
         response_seen++;
      end
   end

   // Reset, the tests in turn, then drain and the verdict.
   initial begin
      int waited;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.text_byte  = '0;
      req_bus.buffer_end = 1'b0;
      clear_model();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_replies();
      test_long_line();

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // Wait for the last responses, then keep watching for strays.
      waited = 0;
      while (pending_results.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         report_error($sformatf("%0d responses never arrived", pending_results.size()));
      end
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
